@@ sv/fncl_pkg.sv @@
package fncl_pkg;

	localparam int FUNC_W       = 2;
	localparam int CLUSTER_W    = 28;
	localparam int CACHE_ADDR_W = 11;
	localparam int BYTE_W       = 8;
	localparam int SECTOR_W     = 21;
	localparam int NEXT_W       = 32;
	localparam int FAT_TYPE_W   = 2;

	// byte offset of a FAT32 entry reaches cluster*4
	localparam int OFF_W       = CLUSTER_W + 2;
	localparam int CACHE_SPAN  = 1 << CACHE_ADDR_W;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd2;

	localparam logic [FAT_TYPE_W-1:0] FAT_12 = 2'd0;
	localparam logic [FAT_TYPE_W-1:0] FAT_16 = 2'd1;

	localparam logic [11:0] EOC_12 = 12'hFF8;
	localparam logic [15:0] EOC_16 = 16'hFFF8;
	localparam logic [27:0] EOC_32 = 28'hFFFFFF8;
	localparam logic [NEXT_W-1:0] EXT_12 = 32'hFFFFF000;
	localparam logic [NEXT_W-1:0] EXT_16 = 32'hFFFF0000;
	localparam logic [NEXT_W-1:0] EXT_32 = 32'hF0000000;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [CLUSTER_W-1:0]    cluster;
		logic [CACHE_ADDR_W-1:0] cache_addr;
		logic [BYTE_W-1:0]       fill_byte;
		logic [SECTOR_W-1:0]     window_sector;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [NEXT_W-1:0]   next_cluster;
		logic [SECTOR_W-1:0] need_sector;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_FILL   = 2'd1,
		OP_SET    = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t                kind;
		logic [FAT_TYPE_W-1:0]   fat;
		logic [OFF_W-1:0]        off;
		logic [OFF_W:0]          off_end;
		logic                    odd;
		logic [CACHE_ADDR_W-1:0] addr;
		logic [BYTE_W-1:0]       data;
		logic [SECTOR_W-1:0]     sector;
	} op_t;

endpackage

@@ sv/fncl_ram.sv @@
module fncl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/fncl_front.sv @@
module fncl_front
	import fncl_pkg::*;
#(
	parameter int STORE_BYTES = 2048
) (
	input  req_t                  req,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic [FAT_TYPE_W-1:0] fat_type,
	input  logic                  queue_full,
	output logic                  push,
	output op_t                   push_op
);

	logic             keep;
	logic [OFF_W-1:0] clus_w;
	logic [OFF_W-1:0] off;
	logic [2:0]       span;

	assign req_ready = !queue_full;
	assign clus_w    = OFF_W'(req.cluster);

	// entry offset: 1.5, 2 or 4 bytes per cluster
	always_comb begin
		unique case (fat_type)
			FAT_12: begin
				off  = clus_w + (clus_w >> 1);
				span = 3'd2;
			end
			FAT_16: begin
				off  = clus_w << 1;
				span = 3'd2;
			end
			default: begin
				off  = clus_w << 2;
				span = 3'd4;
			end
		endcase
	end

	// drop undefined functions and fills that land past the store
	always_comb begin
		push_op.fat     = fat_type;
		push_op.off     = off;
		push_op.off_end = (OFF_W + 1)'(off) + (OFF_W + 1)'(span);
		push_op.odd     = req.cluster[0];
		push_op.addr    = req.cache_addr;
		push_op.data    = req.fill_byte;
		push_op.sector  = req.window_sector;
		unique case (req.func)
			FUNC_LOOKUP: begin
				keep         = 1'b1;
				push_op.kind = OP_LOOKUP;
			end
			FUNC_FILL: begin
				keep         = (32'(req.cache_addr) < 32'(STORE_BYTES));
				push_op.kind = OP_FILL;
			end
			FUNC_SET: begin
				keep         = 1'b1;
				push_op.kind = OP_SET;
			end
			default: begin
				keep         = 1'b0;
				push_op.kind = OP_LOOKUP;
			end
		endcase
	end

	assign push = req_valid && req_ready && keep;

endmodule

@@ sv/fncl_fifo.sv @@
module fncl_fifo
	import fncl_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/fncl_back.sv @@
module fncl_back
	import fncl_pkg::*;
#(
	parameter int WINDOW_SECTORS = 4,
	parameter int SECTOR_BYTES   = 512
) (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  op_t  head_op,
	output logic pop,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);

	localparam int STORE_BYTES = WINDOW_SECTORS * SECTOR_BYTES;
	localparam int MEM_BYTES   = (STORE_BYTES < CACHE_SPAN) ? STORE_BYTES : CACHE_SPAN;
	localparam int BANK_DEPTH  = MEM_BYTES / 4;
	localparam int ROW_W       = $clog2(BANK_DEPTH);
	localparam int SB_W        = $clog2(SECTOR_BYTES + 1);
	localparam int BASE_W      = SECTOR_W + 1 + SB_W;
	localparam int CMP_W       = (BASE_W > OFF_W + 1) ? BASE_W : OFF_W + 1;
	// sector = floor(off / SECTOR_BYTES) as a reciprocal multiply, exact for OFF_W bits
	localparam int MUL_W       = OFF_W + 1;
	localparam int PROD_W      = OFF_W + MUL_W;
	localparam int DIV_SH      = OFF_W + $clog2(SECTOR_BYTES);
	localparam logic [63:0] DIV_MUL_WIDE =
		((64'd1 << DIV_SH) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
	localparam logic [MUL_W-1:0] DIV_MUL = DIV_MUL_WIDE[MUL_W-1:0];

	logic              base_valid_q;
	logic [BASE_W-1:0] lo_q;
	logic [BASE_W-1:0] hi_q;

	logic              adv_out;
	logic              s2_free;
	logic              is_lookup;
	logic              is_fill;
	logic              is_set;
	logic              do_lookup;
	logic              hit;
	logic [OFF_W-1:0]  rel;
	logic [ROW_W-1:0]  rel_row;
	logic [1:0]        rel_sel;

	logic                  valid_s2;
	logic                  hit_s2;
	logic                  odd_s2;
	logic [FAT_TYPE_W-1:0] fat_s2;
	logic [1:0]            sel_s2;
	logic [PROD_W-1:0]     prod_s2;

	logic [BYTE_W-1:0] bank_rd [4];
	logic [31:0]       word;
	logic [11:0]       v12;
	logic [27:0]       v28;
	logic [NEXT_W-1:0] next_val;
	logic [PROD_W-1:0] quot;
	rsp_t              rsp_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	assign adv_out   = !rsp_valid_q || rsp_ready;
	assign s2_free   = !valid_s2 || adv_out;
	assign is_lookup = (head_op.kind == OP_LOOKUP);
	assign is_fill   = (head_op.kind == OP_FILL);
	assign is_set    = (head_op.kind == OP_SET);
	// fills and base updates retire at once; a lookup waits for stage two
	assign pop       = head_valid && (!is_lookup || s2_free);
	assign do_lookup = pop && is_lookup;

	assign hit = base_valid_q
		&& (CMP_W'(head_op.off) >= CMP_W'(lo_q))
		&& (CMP_W'(head_op.off_end) <= CMP_W'(hi_q));
	assign rel     = head_op.off - OFF_W'(lo_q);
	assign rel_row = rel[ROW_W+1:2];
	assign rel_sel = rel[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q <= 1'b0;
		end else if (pop && is_set) begin
			base_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_set) begin
			lo_q <= BASE_W'(head_op.sector) * BASE_W'(SECTOR_BYTES);
			hi_q <= (BASE_W'(head_op.sector) + BASE_W'(WINDOW_SECTORS))
				* BASE_W'(SECTOR_BYTES);
		end
	end

	// four byte banks, interleaved on the low address bits
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [ROW_W-1:0] rd_row;
		logic             wr_en;

		assign rd_row = (2'(b) < rel_sel) ? rel_row + ROW_W'(1) : rel_row;
		assign wr_en  = pop && is_fill && (head_op.addr[1:0] == 2'(b));

		fncl_ram #(
			.WIDTH (BYTE_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_en),
			.waddr (head_op.addr[ROW_W+1:2]),
			.wdata (head_op.data),
			.re    (do_lookup),
			.raddr (rd_row),
			.rdata (bank_rd[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= do_lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (do_lookup) begin
			hit_s2  <= hit;
			odd_s2  <= head_op.odd;
			fat_s2  <= head_op.fat;
			sel_s2  <= rel_sel;
			prod_s2 <= PROD_W'(head_op.off) * PROD_W'(DIV_MUL);
		end
	end

	// little-endian word starting at the entry's first byte
	assign word = {bank_rd[2'(sel_s2 + 2'd3)], bank_rd[2'(sel_s2 + 2'd2)],
		bank_rd[2'(sel_s2 + 2'd1)], bank_rd[sel_s2]};
	assign v12  = odd_s2 ? word[15:4] : word[11:0];
	assign v28  = word[27:0];
	assign quot = prod_s2 >> DIV_SH;

	always_comb begin
		unique case (fat_s2)
			FAT_12: begin
				next_val = NEXT_W'(v12) | ((v12 >= EOC_12) ? EXT_12 : '0);
			end
			FAT_16: begin
				next_val = NEXT_W'(word[15:0]) | ((word[15:0] >= EOC_16) ? EXT_16 : '0);
			end
			default: begin
				next_val = NEXT_W'(v28) | ((v28 >= EOC_32) ? EXT_32 : '0);
			end
		endcase
	end

	always_comb begin
		rsp_d.hit = hit_s2;
		if (hit_s2) begin
			rsp_d.next_cluster = next_val;
			rsp_d.need_sector  = '0;
		end else begin
			rsp_d.next_cluster = '0;
			rsp_d.need_sector  = SECTOR_W'(quot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_out) begin
			rsp_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

@@ sv/fat_next_cluster_lookup_top.sv @@
// FAT next-cluster lookup over a host-loaded window of FAT sectors.
//
// Request channel (req_valid/req_ready, payload req): func selects a lookup,
// a one-byte fill of the window store, or a new window base sector. Fills
// and base updates give no response; every lookup gives exactly one.
// Response channel (rsp_valid/rsp_ready, payload rsp): on a hit, next_cluster
// holds the chain successor with end-of-chain codes padded with ones above; on
// a miss, need_sector names the FAT sector where the host should load a new
// window, then refill the store and set the base.
// cfg_we/cfg_wdata write the FAT type (FAT12, FAT16, FAT32); write it only
// while no request is in flight.
// Throughput: one request per cycle while the queue is not full. A lookup
// is queued on acceptance; popping it registers the range check, bank read
// and reciprocal multiply into stage two, and the response register then
// takes the assembled bytes.
// A four-entry queue parts the front from the back, so requests keep being
// taken while the receiver stalls until the queue fills; a stalled lookup
// holds its bank read data and blocks the next lookup and all queued behind it.
// Reset: FAT12, no window loaded (every lookup misses); store contents are
// undefined until filled.
module fat_next_cluster_lookup_top
	import fncl_pkg::*;
#(
	parameter int WINDOW_SECTORS = 4,
	parameter int SECTOR_BYTES   = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [FAT_TYPE_W-1:0] cfg_wdata
);

	logic [FAT_TYPE_W-1:0] fat_type_q;

	logic queue_full;
	logic push;
	op_t  push_op;
	logic pop;
	logic head_valid;
	op_t  head_op;

	// hold the FAT type; requests in flight carry their own copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_type_q <= FAT_12;
		end else if (cfg_we) begin
			fat_type_q <= cfg_wdata;
		end
	end

	// classify the request and compute its FAT entry offset
	fncl_front #(
		.STORE_BYTES (WINDOW_SECTORS * SECTOR_BYTES)
	) u_front (
		.req        (req),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.fat_type   (fat_type_q),
		.queue_full (queue_full),
		.push       (push),
		.push_op    (push_op)
	);

	// decouple intake from execution
	fncl_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	// execute fills, base updates and lookups in order
	fncl_back #(
		.WINDOW_SECTORS (WINDOW_SECTORS),
		.SECTOR_BYTES   (SECTOR_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.rsp        (rsp),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready)
	);

endmodule

@@ sim/fat_next_cluster_lookup_top_tb.sv @@
module fat_next_cluster_lookup_top_tb;
	import fncl_pkg::*;

	localparam int WIN_SECTORS   = 4;
	localparam int SEC_BYTES     = 512;
	localparam int STORE_BYTES   = WIN_SECTORS * SEC_BYTES;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 215;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 1000000;

	// FAT32, and the spare code that the block decodes as FAT32
	localparam logic [FAT_TYPE_W-1:0] FAT_32    = 2'd2;
	localparam logic [FAT_TYPE_W-1:0] FAT_SPARE = 2'd3;
	// spare function code: the block drops it without a response
	localparam logic [FUNC_W-1:0]     FUNC_NONE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp;
	logic                  cfg_we;
	logic [FAT_TYPE_W-1:0] cfg_wdata;

	// Shadow of the window store, window base and FAT type; holds the
	// next-cluster results still owed by the block, oldest first.
	class fat_chain_model;
		logic [7:0]            store [STORE_BYTES];
		bit                    filled [STORE_BYTES];
		logic [31:0]           base;
		logic [FAT_TYPE_W-1:0] fat;
		rsp_t                  links [$];
		int                    errors;

		function new();
			base   = '1;
			fat    = FAT_12;
			errors = 0;
			foreach (filled[i]) begin
				filled[i] = 0;
				store[i]  = '0;
			end
		endfunction

		// Find the entry of a cluster: byte offset, width, and whether it
		// lies wholly in the window.
		function void locate(input logic [CLUSTER_W-1:0] clus, output logic [63:0] off,
			output int nbytes, output bit in_window);
			logic [63:0] lo;
			logic [63:0] hi;
			if (fat == FAT_12) begin
				off    = 64'(clus) * 3 / 2;
				nbytes = 2;
			end else if (fat == FAT_16) begin
				off    = 64'(clus) * 2;
				nbytes = 2;
			end else begin
				off    = 64'(clus) * 4;
				nbytes = 4;
			end
			lo        = 64'(base) * SEC_BYTES;
			hi        = (64'(base) + WIN_SECTORS) * SEC_BYTES;
			in_window = off >= lo && off + 64'(nbytes) <= hi;
		endfunction

		function rsp_t next_link(input logic [CLUSTER_W-1:0] clus);
			rsp_t        r;
			logic [63:0] off;
			int          nbytes;
			bit          in_window;
			int          p;
			logic [31:0] v;
			locate(clus, off, nbytes, in_window);
			r = '0;
			if (!in_window) begin
				r.need_sector = SECTOR_W'(off / SEC_BYTES);
				return r;
			end
			p = int'(off - 64'(base) * SEC_BYTES);
			v = {24'd0, store[p]} | {16'd0, store[p + 1], 8'd0};
			if (fat == FAT_12) begin
				// odd clusters sit in the upper twelve bits of the pair
				v = clus[0] ? v >> 4 : v & 32'h0FFF;
				if (v >= 32'(EOC_12))
					v |= EXT_12;
			end else if (fat == FAT_16) begin
				if (v >= 32'(EOC_16))
					v |= EXT_16;
			end else begin
				v |= {store[p + 3], store[p + 2], 16'd0};
				v &= 32'h0FFFFFFF;
				if (v >= 32'(EOC_32))
					v |= EXT_32;
			end
			r.hit          = 1'b1;
			r.next_cluster = v;
			return r;
		endfunction

		function void take_request(input req_t r);
			case (r.func)
				FUNC_FILL: begin
					store[r.cache_addr]  = r.fill_byte;
					filled[r.cache_addr] = 1;
				end
				FUNC_SET:    base = 32'(r.window_sector);
				FUNC_LOOKUP: links.push_back(next_link(r.cluster));
				default: ;
			endcase
		endfunction

		function void check_link(input rsp_t got);
			rsp_t want;
			if (links.size() == 0) begin
				$error("response with no lookup waiting: hit %0d next %0h sector %0h",
					got.hit, got.next_cluster, got.need_sector);
				errors++;
				return;
			end
			want = links.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, actual %0d", want.hit, got.hit);
				errors++;
			end
			if (got.next_cluster !== want.next_cluster) begin
				$error("next_cluster: expected %0h, actual %0h", want.next_cluster,
					got.next_cluster);
				errors++;
			end
			if (got.need_sector !== want.need_sector) begin
				$error("need_sector: expected %0h, actual %0h", want.need_sector,
					got.need_sector);
				errors++;
			end
		endfunction
	endclass

	fat_chain_model chain;
	bit             calm = 0;
	int             requests_sent = 0;
	int             cycles = 0;

	fat_next_cluster_lookup_top #(
		.WINDOW_SECTORS(WIN_SECTORS),
		.SECTOR_BYTES  (SEC_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Watch both channels and the register port at the rising edge; inputs
	// only move at the falling edge, so everything seen here is settled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				chain.fat = cfg_wdata;
			if (req_valid && req_ready)
				chain.take_request(req);
			if (rsp_valid && rsp_ready)
				chain.check_link(rsp);
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: stall in random bursts, stay ready otherwise;
	// once the run turns calm, never stall again.
	initial begin
		int hold;
		rsp_ready = 0;
		hold      = 0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp_ready = 0;
				hold      = $urandom_range(1, 14) - 1;
			end else begin
				rsp_ready = 1;
			end
		end
	end

	// Fill all fields with noise; the caller overrides what matters.
	function automatic req_t random_request(input logic [FUNC_W-1:0] func);
		req_t r;
		r.func          = func;
		r.cluster       = CLUSTER_W'($urandom);
		r.cache_addr    = CACHE_ADDR_W'($urandom);
		r.fill_byte     = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
		r.window_sector = SECTOR_W'($urandom);
		return r;
	endfunction

	// Enter at a falling edge, optionally idle first, hold valid and payload
	// until accepted, and leave at the next falling edge with valid still up.
	task automatic send_request(input req_t r);
		if (!calm && $urandom_range(0, 9) == 0) begin
			req_valid = 0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		req       = r;
		req_valid = 1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
		if (r.func != FUNC_NONE)
			requests_sent++;
	endtask

	// Issue a lookup. If the entry falls in the window, first fill any of
	// its bytes never written; with chain_end, rewrite all of them with a
	// pattern near or above the end-of-chain threshold.
	task automatic issue_lookup(input logic [CLUSTER_W-1:0] clus, input bit chain_end);
		logic [63:0] off;
		int          nbytes;
		bit          in_window;
		int          p;
		bit          odd12;
		logic [7:0]  b;
		req_t        r;
		chain.locate(clus, off, nbytes, in_window);
		if (in_window) begin
			p     = int'(off - 64'(chain.base) * SEC_BYTES);
			odd12 = chain.fat == FAT_12 && clus[0];
			for (int k = 0; k < nbytes; k++) begin
				if (chain.filled[p + k] && !chain_end)
					continue;
				b = 8'($urandom);
				if (chain_end) begin
					if (k == 0)
						b = odd12 ? {4'($urandom_range(6, 15)), b[3:0]}
							: 8'($urandom_range(8'hF0, 8'hFF));
					else if (k == nbytes - 1 && !odd12 && chain.fat != FAT_16)
						b[3:0] = 4'hF;
					else
						b = 8'hFF;
				end
				r            = random_request(FUNC_FILL);
				r.cache_addr = CACHE_ADDR_W'(p + k);
				r.fill_byte  = b;
				send_request(r);
			end
		end
		r         = random_request(FUNC_LOOKUP);
		r.cluster = clus;
		send_request(r);
	endtask

	// One random step: mostly lookups aimed into the loaded window, plus
	// stray fills, window moves, wild clusters and dropped function codes.
	task automatic random_step();
		int                   pick;
		int                   sel;
		req_t                 r;
		logic [63:0]          spot;
		logic [CLUSTER_W-1:0] clus;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			r   = random_request(FUNC_SET);
			sel = $urandom_range(0, 9);
			if (sel < 5)
				r.window_sector = SECTOR_W'($urandom_range(0, 64));
			else if (sel >= 8)
				r.window_sector = SECTOR_W'(-1 - $urandom_range(0, 3));
			send_request(r);
		end else if (pick < 8) begin
			send_request(random_request(FUNC_NONE));
		end else if (pick < 22) begin
			send_request(random_request(FUNC_FILL));
		end else begin
			if (chain.base < 32'h0020_0000 && $urandom_range(0, 9) < 7) begin
				spot = 64'(chain.base) * SEC_BYTES;
				case ($urandom_range(0, 9))
					0:       spot += $urandom_range(0, 7);
					1:       spot += $urandom_range(STORE_BYTES - 8, STORE_BYTES - 1);
					default: spot += $urandom_range(0, STORE_BYTES - 1);
				endcase
				if (chain.fat == FAT_12)
					clus = CLUSTER_W'(spot * 2 / 3);
				else if (chain.fat == FAT_16)
					clus = CLUSTER_W'(spot / 2);
				else
					clus = CLUSTER_W'(spot / 4);
			end else begin
				clus = CLUSTER_W'($urandom);
			end
			issue_lookup(clus, $urandom_range(0, 3) == 0);
		end
	endtask

	// Drop valid, drain every owed result, let queued fills settle, then
	// write the FAT type.
	task automatic write_fat(input logic [FAT_TYPE_W-1:0] value);
		req_valid = 0;
		while (chain.links.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 0;
	endtask

	initial begin
		req_t                  r;
		logic [FAT_TYPE_W-1:0] order [PHASES];
		int                    target;
		chain     = new();
		arst_n    = 0;
		req_valid = 0;
		req       = '0;
		cfg_we    = 0;
		cfg_wdata = FAT_12;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: FAT12 from reset, no window loaded, so both extremes miss.
		issue_lookup('0, 0);
		issue_lookup('1, 0);
		send_request(random_request(FUNC_NONE));
		// Load the window at sector zero; hit even and odd entries at the
		// chain end, the last whole entry, one straddling the window end,
		// and one just past it.
		r               = random_request(FUNC_SET);
		r.window_sector = '0;
		send_request(r);
		issue_lookup(CLUSTER_W'(0), 1);
		issue_lookup(CLUSTER_W'(1), 1);
		issue_lookup(CLUSTER_W'(1364), 0);
		issue_lookup(CLUSTER_W'(1365), 0);
		issue_lookup(CLUSTER_W'(1366), 0);

		// Random phases over every FAT type code; the last one runs with no
		// idling on either side.
		order = '{FAT_16, FAT_32, FAT_SPARE, FAT_12, FAT_32, FAT_16, FAT_12, FAT_32};
		for (int ph = 0; ph < PHASES; ph++) begin
			write_fat(order[ph]);
			calm            = ph == PHASES - 1;
			r               = random_request(FUNC_SET);
			r.window_sector = SECTOR_W'($urandom_range(0, 16));
			send_request(r);
			target = requests_sent + PHASE_ITEMS;
			while (requests_sent < target)
				random_step();
		end

		req_valid = 0;
		while (chain.links.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (chain.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
sv/fncl_pkg.sv
sv/fncl_ram.sv
sv/fncl_front.sv
sv/fncl_fifo.sv
sv/fncl_back.sv
sv/fat_next_cluster_lookup_top.sv
sim/fat_next_cluster_lookup_top_tb.sv
